@@ rtl/ihmm_pkg.sv @@
// Shared types and constants for the image histogram with frame minimum and maximum.
// Used by every module of the block; depends on nothing else.

package ihmm_pkg;

	// Histogram geometry
	localparam int NUM_BINS = 1024;
	localparam int BIN_AW   = $clog2(NUM_BINS);

	// Frame epoch mark kept beside each bin count
	localparam int                 EPOCH_W    = 8;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST = {EPOCH_W{1'b1}};

	// Saturation limit of a bin count
	localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// Pixel format codes of the mode register
	localparam logic [1:0] MODE_8BIT  = 2'd0;
	localparam logic [1:0] MODE_12BIT = 2'd1;
	localparam logic [1:0] MODE_16BIT = 2'd2;

	// Item operation codes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Input beat
	typedef struct packed {
		logic        op;
		logic [15:0] pixel;
		logic        first_of_frame;
		logic [9:0]  bin_index;
	} in_beat_t;

	// Result beat
	typedef struct packed {
		logic [15:0] min_value;
		logic [15:0] max_value;
		logic [31:0] bin_count;
	} out_beat_t;

	// Classified command passed from front to back
	typedef struct packed {
		logic              is_pixel;
		logic              frame_start;
		logic [15:0]       value;
		logic [BIN_AW-1:0] addr;
		logic              rd_ok;
	} cmd_t;

	// One histogram memory word
	typedef struct packed {
		logic [EPOCH_W-1:0] tag;
		logic [31:0]        count;
	} bin_word_t;

	// Back-end status
	typedef struct packed {
		logic clearing;
		logic s1_valid;
		logic wr_en;
	} bk_status_t;

endpackage

@@ rtl/ihmm_front.sv @@
// Front end: masks pixels to the selected format, derives the bin address and range flag.
// Depends on ihmm_pkg.

module ihmm_front (
	input  logic              in_valid,
	output logic              in_ready,
	input  ihmm_pkg::in_beat_t in_data,
	input  logic [1:0]        pixel_mode,
	input  logic              clearing,
	output logic              push_valid,
	input  logic              push_ready,
	output ihmm_pkg::cmd_t    push_cmd
);

	logic [15:0]                 value;
	logic [9:0]                  raw_bin;
	logic [ihmm_pkg::BIN_AW-1:0] pix_addr;

	// Mask the pixel and pick its raw bin
	always_comb begin
		unique case (pixel_mode)
			ihmm_pkg::MODE_8BIT: begin
				value   = {8'b0, in_data.pixel[7:0]};
				raw_bin = {2'b0, in_data.pixel[7:0]};
			end
			ihmm_pkg::MODE_12BIT: begin
				value   = {4'b0, in_data.pixel[11:0]};
				raw_bin = in_data.pixel[11:2];
			end
			default: begin
				value   = in_data.pixel;
				raw_bin = in_data.pixel[15:6];
			end
		endcase
	end

	// Clamp a bin beyond the table to the last bin
	always_comb begin
		if (int'(raw_bin) >= ihmm_pkg::NUM_BINS) begin
			pix_addr = ihmm_pkg::BIN_AW'(ihmm_pkg::NUM_BINS - 1);
		end else begin
			pix_addr = ihmm_pkg::BIN_AW'(raw_bin);
		end
	end

	// Build the command
	always_comb begin
		push_cmd.is_pixel    = (in_data.op == ihmm_pkg::OP_PIXEL);
		push_cmd.frame_start = (in_data.op == ihmm_pkg::OP_PIXEL) && in_data.first_of_frame;
		push_cmd.value       = value;
		push_cmd.rd_ok       = (int'(in_data.bin_index) < ihmm_pkg::NUM_BINS);
		if (in_data.op == ihmm_pkg::OP_PIXEL) begin
			push_cmd.addr = pix_addr;
		end else begin
			push_cmd.addr = ihmm_pkg::BIN_AW'(in_data.bin_index);
		end
	end

	// Hold off input while the histogram memory is swept
	assign push_valid = in_valid && !clearing;
	assign in_ready   = push_ready && !clearing;

endmodule

@@ rtl/ihmm_queue.sv @@
// Short command queue decoupling the front end from the back end.
// Depends on ihmm_pkg.

module ihmm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  ihmm_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output ihmm_pkg::cmd_t pop_cmd
);

	ihmm_pkg::cmd_t              entry_q [ihmm_pkg::QUEUE_DEPTH];
	logic [ihmm_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [ihmm_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [ihmm_pkg::QPTR_W:0]   count_q;
	logic                        push;
	logic                        pop;

	assign push_ready = (int'(count_q) != ihmm_pkg::QUEUE_DEPTH);
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Store a pushed beat
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (int'(wr_ptr_q) == ihmm_pkg::QUEUE_DEPTH - 1) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (int'(rd_ptr_q) == ihmm_pkg::QUEUE_DEPTH - 1) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/ihmm_back.sv @@
// Back end: histogram memory read-modify-write, frame extremes, epoch marks and sweep,
// and the output register. Depends on ihmm_pkg.

module ihmm_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_valid,
	output logic                 q_ready,
	input  ihmm_pkg::cmd_t       q_cmd,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ihmm_pkg::out_beat_t  out_data,
	output ihmm_pkg::bk_status_t status
);

	// Memory and read register
	ihmm_pkg::bin_word_t bin_mem_q [ihmm_pkg::NUM_BINS];
	ihmm_pkg::bin_word_t rdata_s1;

	// Stage one
	ihmm_pkg::cmd_t cmd_s1;
	logic           s1_valid_q;

	// Frame state
	logic [ihmm_pkg::EPOCH_W-1:0] epoch_q;
	logic [15:0]                  min_q;
	logic [15:0]                  max_q;

	// Sweep
	logic                        clr_active_q;
	logic [ihmm_pkg::BIN_AW-1:0] clr_addr_q;

	// Last write, forwarded to the following item
	logic                        fwd_valid_q;
	logic [ihmm_pkg::BIN_AW-1:0] fwd_addr_q;
	ihmm_pkg::bin_word_t         fwd_word_q;

	// Output register
	logic                out_valid_q;
	ihmm_pkg::out_beat_t out_q;

	logic                         advance;
	logic                         s1_adv;
	logic                         pop;
	logic [ihmm_pkg::EPOCH_W-1:0] epoch_ahead;
	logic                         wrap_hold;
	logic                         clr_start;
	ihmm_pkg::bin_word_t          word;
	logic [31:0]                  cur;
	logic [31:0]                  inc;
	logic [ihmm_pkg::EPOCH_W-1:0] wr_tag;
	logic                         wr_en;
	logic [15:0]                  base_min;
	logic [15:0]                  base_max;
	logic [15:0]                  new_min;
	logic [15:0]                  new_max;
	ihmm_pkg::out_beat_t          result;
	logic                         mem_we;
	logic [ihmm_pkg::BIN_AW-1:0]  mem_waddr;
	ihmm_pkg::bin_word_t          mem_wdata;

	// Flow control
	assign advance     = !out_valid_q || out_ready;
	assign s1_adv      = s1_valid_q && advance;
	assign epoch_ahead = (s1_valid_q && cmd_s1.frame_start) ? epoch_q + 1'b1 : epoch_q;
	assign wrap_hold   = q_valid && q_cmd.frame_start && (epoch_ahead == ihmm_pkg::EPOCH_LAST);
	assign clr_start   = wrap_hold && !s1_valid_q && !clr_active_q;
	assign q_ready     = !clr_active_q && !wrap_hold && (!s1_valid_q || advance);
	assign pop         = q_valid && q_ready;

	// Pick up the newest copy of the addressed bin
	always_comb begin
		if (fwd_valid_q && (fwd_addr_q == cmd_s1.addr)) begin
			word = fwd_word_q;
		end else begin
			word = rdata_s1;
		end
	end

	// Bin update: a frame start or stale epoch reads as zero, count saturates
	always_comb begin
		if (cmd_s1.frame_start || (word.tag != epoch_q)) begin
			cur = '0;
		end else begin
			cur = word.count;
		end
		inc    = (cur == ihmm_pkg::COUNT_MAX) ? cur : cur + 32'd1;
		wr_tag = cmd_s1.frame_start ? epoch_q + 1'b1 : epoch_q;
		wr_en  = s1_adv && cmd_s1.is_pixel;
	end

	// Frame extremes
	always_comb begin
		base_min = cmd_s1.frame_start ? cmd_s1.value : min_q;
		base_max = cmd_s1.frame_start ? cmd_s1.value : max_q;
		new_min  = base_min;
		new_max  = base_max;
		if (cmd_s1.value < base_min) begin
			new_min = cmd_s1.value;
		end else if (cmd_s1.value > base_max) begin
			new_max = cmd_s1.value;
		end
	end

	// Result beat
	always_comb begin
		result.min_value = cmd_s1.is_pixel ? new_min : min_q;
		result.max_value = cmd_s1.is_pixel ? new_max : max_q;
		if (!cmd_s1.is_pixel && cmd_s1.rd_ok) begin
			result.bin_count = cur;
		end else begin
			result.bin_count = '0;
		end
	end

	// Memory write port: sweep or bin update
	always_comb begin
		if (clr_active_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we          = wr_en;
			mem_waddr       = cmd_s1.addr;
			mem_wdata.tag   = wr_tag;
			mem_wdata.count = inc;
		end
	end

	// Histogram memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem_q[mem_waddr] <= mem_wdata;
		end
		if (pop) begin
			rdata_s1 <= bin_mem_q[q_cmd.addr];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= q_cmd;
		end
		if (s1_adv) begin
			out_q <= result;
		end
		if (wr_en) begin
			fwd_addr_q       <= cmd_s1.addr;
			fwd_word_q.tag   <= wr_tag;
			fwd_word_q.count <= inc;
		end
	end

	// Control and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			epoch_q      <= '0;
			min_q        <= '0;
			max_q        <= '0;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			fwd_valid_q  <= 1'b0;
		end else begin
			// Advance stage one
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			// Hold or drop the output beat
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			// Frame state update
			if (wr_en) begin
				min_q <= new_min;
				max_q <= new_max;
			end
			if (clr_start) begin
				epoch_q <= '0;
			end else if (s1_adv && cmd_s1.frame_start) begin
				epoch_q <= epoch_q + 1'b1;
			end
			// Sweep the memory
			if (clr_start) begin
				clr_active_q <= 1'b1;
				clr_addr_q   <= '0;
			end else if (clr_active_q) begin
				if (int'(clr_addr_q) == ihmm_pkg::NUM_BINS - 1) begin
					clr_active_q <= 1'b0;
				end else begin
					clr_addr_q <= clr_addr_q + 1'b1;
				end
			end
			// Track the forwarded write
			if (clr_active_q || clr_start) begin
				fwd_valid_q <= 1'b0;
			end else if (wr_en) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_data        = out_q;
	assign status.clearing = clr_active_q;
	assign status.s1_valid = s1_valid_q;
	assign status.wr_en    = wr_en;

endmodule

@@ rtl/image_histogram_min_max.sv @@
// Image histogram with per-frame minimum and maximum. An accepted item passes the queue,
// stage one and the output register before its result is offered. Throughput: one item per
// cycle unless the output stalls or a sweep runs, with last-write forwarding on the memory
// read-modify-write. After reset the memory is swept before items are taken; the 256th frame
// start after reset, and every 255th one after that, repeats that sweep (epoch mark wrap)
// after the back end drains. Depends on ihmm_pkg, ihmm_front, ihmm_queue and ihmm_back.

module image_histogram_min_max (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ihmm_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ihmm_pkg::out_beat_t out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata
);

	logic                 [1:0] pixel_mode_q;
	logic                       push_valid;
	logic                       push_ready;
	ihmm_pkg::cmd_t             push_cmd;
	logic                       q_valid;
	logic                       q_ready;
	ihmm_pkg::cmd_t             q_cmd;
	ihmm_pkg::bk_status_t       bk_status;

	// Hold the pixel format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q <= ihmm_pkg::MODE_16BIT;
		end else if (cfg_we) begin
			pixel_mode_q <= cfg_wdata;
		end
	end

	ihmm_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.pixel_mode (pixel_mode_q),
		.clearing   (bk_status.clearing),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	ihmm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_cmd    (q_cmd)
	);

	ihmm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.status    (bk_status)
	);

	// No command leaves the queue during a sweep
	a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.clearing |-> !(q_valid && q_ready))
		else $error("command popped during memory sweep");

	// A sweep only runs with stage one empty
	a_sweep_drained: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.clearing |-> !bk_status.s1_valid)
		else $error("memory sweep with an item in stage one");

	// A bin write comes only from an occupied stage one outside a sweep
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		bk_status.wr_en |-> (bk_status.s1_valid && !bk_status.clearing))
		else $error("bin write without a pixel in stage one");

	// A popped command reaches stage one
	a_pop_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(q_valid && q_ready) |=> bk_status.s1_valid)
		else $error("popped command lost before stage one");

endmodule
